// ===== rtl/bsdf_pkg.sv =====
// Shared types, codes and Q16.16 helpers for the bone spring-damper force block.
`default_nettype none
package bsdf_pkg;

	localparam int FRAC_W = 16;
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int QUO_W  = 17;

	typedef logic signed [31:0] q_t;
	typedef logic [30:0]        uq_t;

	localparam logic [1:0] HINGE_NONE = 2'd0;
	localparam logic [1:0] HINGE_A    = 2'd1;
	localparam logic [1:0] HINGE_B    = 2'd2;

	localparam logic [1:0] CFG_MAX_FORCE     = 2'd0;
	localparam logic [1:0] CFG_SPRING_SCALE  = 2'd1;
	localparam logic [1:0] CFG_DAMPING_SCALE = 2'd2;

	localparam uq_t MAX_FORCE_RST     = 31'd32768;
	localparam uq_t SPRING_SCALE_RST  = 31'd65536;
	localparam uq_t DAMPING_SCALE_RST = 31'd65536;

	typedef struct packed {
		logic       bone_valid;
		q_t         delta_x;
		q_t         delta_y;
		q_t         vel_a_x;
		q_t         vel_a_y;
		q_t         vel_b_x;
		q_t         vel_b_y;
		uq_t        rest_length;
		uq_t        stiffness;
		logic [1:0] pivot_end;
		uq_t        rot_damping;
	} in_item_t;

	typedef struct packed {
		logic       applied;
		q_t         force_x;
		q_t         force_y;
		logic [1:0] rot_target;
		q_t         rot_force_x;
		q_t         rot_force_y;
	} out_item_t;

	typedef struct packed {
		logic       bone_valid;
		q_t         dx;
		q_t         dy;
		q_t         rvx;
		q_t         rvy;
		q_t         vx;
		q_t         vy;
		uq_t        rest;
		uq_t        stiff;
		logic [1:0] hinge;
		uq_t        rdamp;
	} bone_ctx_t;

	typedef struct packed {
		bone_ctx_t             ctx;
		logic [ROOT_W-1:0]     len;
	} div_ctx_t;

	typedef struct packed {
		logic       applied;
		q_t         fx;
		q_t         fy;
		q_t         cfx;
		q_t         cfy;
		logic [1:0] target;
		q_t         rfx;
		q_t         rfy;
	} force_ctx_t;

	function automatic q_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// floor(p / 2^16), saturated
	function automatic q_t qscale(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p >>> FRAC_W;
		return sat32(t);
	endfunction

	function automatic logic signed [63:0] mul32(input q_t a, input q_t b);
		return 64'(a) * 64'(b);
	endfunction

	function automatic q_t sat_add(input q_t a, input q_t b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic q_t sat_sub(input q_t a, input q_t b);
		return sat32(64'(a) - 64'(b));
	endfunction

	function automatic q_t to_q(input uq_t u);
		return $signed({1'b0, u});
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bone_spring_damper_force.sv =====
// 96 register stages from input capture to the output register. Throughput: one
// item per cycle while the skid entry is empty; the two square roots
// (32 stages each) and the 17-stage divider set the depth, not the rate.
// A two-entry output (register plus skid) keeps input open while a result waits.
// Reset (arst_n low, asynchronous) empties the pipe and loads register defaults:
// max_force 0.5, spring_scale 1.0, damping_scale 1.0.
`default_nettype none
module bone_spring_damper_force (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bsdf_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bsdf_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_idx,
	input  wire logic [30:0]         cfg_wdata
);
	import bsdf_pkg::*;

	uq_t max_force_q, spring_scale_q, damping_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_force_q     <= MAX_FORCE_RST;
			spring_scale_q  <= SPRING_SCALE_RST;
			damping_scale_q <= DAMPING_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_FORCE:     max_force_q     <= cfg_wdata;
				CFG_SPRING_SCALE:  spring_scale_q  <= cfg_wdata;
				CFG_DAMPING_SCALE: damping_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic skid_valid_q, out_valid_q;
	logic en;

	// the whole pipe advances unless the skid entry is occupied
	assign en       = !skid_valid_q;
	assign in_ready = en;

	// front: capture, squares, sum
	logic      v_s1, v_s2, v_s3;
	in_item_t  in_s1;
	bone_ctx_t ctx_s2, ctx_s3;
	logic signed [63:0] sqx_s2, sqy_s2;
	logic [RAD_W-1:0]   rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1             <= in_item;
			sqx_s2            <= mul32(in_s1.delta_x, in_s1.delta_x);
			sqy_s2            <= mul32(in_s1.delta_y, in_s1.delta_y);
			ctx_s2.bone_valid <= in_s1.bone_valid;
			ctx_s2.dx         <= in_s1.delta_x;
			ctx_s2.dy         <= in_s1.delta_y;
			ctx_s2.rvx        <= sat_sub(in_s1.vel_b_x, in_s1.vel_a_x);
			ctx_s2.rvy        <= sat_sub(in_s1.vel_b_y, in_s1.vel_a_y);
			// hinge at A rotates end B, otherwise end A
			ctx_s2.vx         <= (in_s1.pivot_end == HINGE_A) ? in_s1.vel_b_x : in_s1.vel_a_x;
			ctx_s2.vy         <= (in_s1.pivot_end == HINGE_A) ? in_s1.vel_b_y : in_s1.vel_a_y;
			ctx_s2.rest       <= in_s1.rest_length;
			ctx_s2.stiff      <= in_s1.stiffness;
			ctx_s2.hinge      <= in_s1.pivot_end;
			ctx_s2.rdamp      <= in_s1.rot_damping;
			rad_s3            <= RAD_W'(sqx_s2) + RAD_W'(sqy_s2);
			ctx_s3            <= ctx_s2;
		end
	end

	// bone length
	logic              dv;
	logic [ROOT_W-1:0] bone_len;
	bone_ctx_t         dctx;

	bsdf_isqrt #(.SIDE_W($bits(bone_ctx_t))) u_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.rad      (rad_s3),
		.side_in  (ctx_s3),
		.out_v    (dv),
		.root     (bone_len),
		.side_out (dctx)
	);

	// unit vector
	div_ctx_t          div_in, div_out;
	logic              qv;
	logic [QUO_W-1:0]  qx, qy;
	logic [31:0]       mag_x, mag_y;

	assign div_in.ctx = dctx;
	assign div_in.len = bone_len;
	assign mag_x = dctx.dx[31] ? ~dctx.dx + 32'd1 : dctx.dx;
	assign mag_y = dctx.dy[31] ? ~dctx.dy + 32'd1 : dctx.dy;

	bsdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (dv),
		.num_a    (mag_x),
		.num_b    (mag_y),
		.den      (bone_len),
		.side_in  (div_in),
		.out_v    (qv),
		.quo_a    (qx),
		.quo_b    (qy),
		.side_out (div_out)
	);

	logic             cv;
	logic [RAD_W-1:0] frad;
	force_ctx_t       fctx;

	bsdf_calc u_calc (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_v          (qv),
		.in_d          (div_out),
		.quo_x         (qx),
		.quo_y         (qy),
		.max_force     (max_force_q),
		.spring_scale  (spring_scale_q),
		.damping_scale (damping_scale_q),
		.out_v         (cv),
		.rad           (frad),
		.side_out      (fctx)
	);

	// force magnitude for the clamp
	logic              mv;
	logic [ROOT_W-1:0] fmag;
	force_ctx_t        mctx;

	bsdf_isqrt #(.SIDE_W($bits(force_ctx_t))) u_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (cv),
		.rad      (frad),
		.side_in  (fctx),
		.out_v    (mv),
		.root     (fmag),
		.side_out (mctx)
	);

	out_item_t res;
	logic      over;

	assign over = fmag > {1'b0, max_force_q};

	always_comb begin
		res.applied     = mctx.applied;
		res.force_x     = !mctx.applied ? 32'sd0 : (over ? mctx.cfx : mctx.fx);
		res.force_y     = !mctx.applied ? 32'sd0 : (over ? mctx.cfy : mctx.fy);
		res.rot_target  = mctx.target;
		res.rot_force_x = mctx.rfx;
		res.rot_force_y = mctx.rfy;
	end

	// output register with one skid entry
	out_item_t out_q, skid_q;
	logic      pop;

	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= mv;
		end else if (mv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// ===== rtl/bsdf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side payload.
`default_nettype none
module bsdf_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_v,
	input  wire logic [bsdf_pkg::RAD_W-1:0] rad,
	input  wire logic [SIDE_W-1:0]          side_in,
	output logic                            out_v,
	output logic [bsdf_pkg::ROOT_W-1:0]     root,
	output logic [SIDE_W-1:0]               side_out
);
	import bsdf_pkg::*;

	localparam int STEPS = ROOT_W;

	logic [RAD_W-1:0]  x_s [0:STEPS];
	logic [RAD_W-1:0]  r_s [0:STEPS];
	logic              v_s [0:STEPS];
	logic [SIDE_W-1:0] d_s [0:STEPS];

	assign x_s[0] = rad;
	assign r_s[0] = '0;
	assign v_s[0] = in_v;
	assign d_s[0] = side_in;

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 * k);
		logic [RAD_W-1:0] trial;
		logic             take;

		assign trial = r_s[k-1] + BIT;
		assign take  = x_s[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k] <= take ? x_s[k-1] - trial : x_s[k-1];
				r_s[k] <= take ? (r_s[k-1] >> 1) + BIT : r_s[k-1] >> 1;
				d_s[k] <= d_s[k-1];
			end
		end
	end

	assign out_v    = v_s[STEPS];
	assign root     = r_s[STEPS][ROOT_W-1:0];
	assign side_out = d_s[STEPS];

endmodule
`default_nettype wire

// ===== rtl/bsdf_div.sv =====
// Pipelined restoring divider: two magnitudes scaled by 2^16 over one divisor.
`default_nettype none
module bsdf_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_v,
	input  wire logic [31:0]                 num_a,
	input  wire logic [31:0]                 num_b,
	input  wire logic [bsdf_pkg::ROOT_W-1:0] den,
	input  wire bsdf_pkg::div_ctx_t          side_in,
	output logic                             out_v,
	output logic [bsdf_pkg::QUO_W-1:0]       quo_a,
	output logic [bsdf_pkg::QUO_W-1:0]       quo_b,
	output bsdf_pkg::div_ctx_t               side_out
);
	import bsdf_pkg::*;

	localparam int STEPS = QUO_W;
	localparam int REM_W = 32 + FRAC_W;

	logic [REM_W-1:0]  ra_s [0:STEPS];
	logic [REM_W-1:0]  rb_s [0:STEPS];
	logic [QUO_W-1:0]  qa_s [0:STEPS];
	logic [QUO_W-1:0]  qb_s [0:STEPS];
	logic [ROOT_W-1:0] dn_s [0:STEPS];
	logic              v_s  [0:STEPS];
	div_ctx_t          d_s  [0:STEPS];

	assign ra_s[0] = {num_a, FRAC_W'(0)};
	assign rb_s[0] = {num_b, FRAC_W'(0)};
	assign qa_s[0] = '0;
	assign qb_s[0] = '0;
	assign dn_s[0] = den;
	assign v_s[0]  = in_v;
	assign d_s[0]  = side_in;

	// the quotient stays below 2^17 because |num| <= den
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [REM_W-1:0] dsh;
		logic             ta;
		logic             tb;

		assign dsh = REM_W'(dn_s[k-1]) << (STEPS - k);
		assign ta  = ra_s[k-1] >= dsh;
		assign tb  = rb_s[k-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k] <= ta ? ra_s[k-1] - dsh : ra_s[k-1];
				rb_s[k] <= tb ? rb_s[k-1] - dsh : rb_s[k-1];
				qa_s[k] <= {qa_s[k-1][QUO_W-2:0], ta};
				qb_s[k] <= {qb_s[k-1][QUO_W-2:0], tb};
				dn_s[k] <= dn_s[k-1];
				d_s[k]  <= d_s[k-1];
			end
		end
	end

	assign out_v    = v_s[STEPS];
	assign quo_a    = qa_s[STEPS];
	assign quo_b    = qb_s[STEPS];
	assign side_out = d_s[STEPS];

endmodule
`default_nettype wire

// ===== rtl/bsdf_calc.sv =====
// Force arithmetic: spring, damping, rotation terms and the squared magnitude.
`default_nettype none
module bsdf_calc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_v,
	input  wire bsdf_pkg::div_ctx_t          in_d,
	input  wire logic [bsdf_pkg::QUO_W-1:0]  quo_x,
	input  wire logic [bsdf_pkg::QUO_W-1:0]  quo_y,
	input  wire bsdf_pkg::uq_t               max_force,
	input  wire bsdf_pkg::uq_t               spring_scale,
	input  wire bsdf_pkg::uq_t               damping_scale,
	output logic                             out_v,
	output logic [bsdf_pkg::RAD_W-1:0]       rad,
	output bsdf_pkg::force_ctx_t             side_out
);
	import bsdf_pkg::*;

	localparam int NST = 11;

	logic [NST:1] v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-1:1], in_v};
		end
	end

	// stage 1: unit vector signs, length error, tangent
	logic       app_s1;
	q_t         ux_s1, uy_s1, err_s1, tx_s1, ty_s1, rvx_s1, rvy_s1, vx_s1, vy_s1;
	uq_t        stiff_s1, rdamp_s1;
	logic [1:0] tgt_s1;
	q_t         ux_c, uy_c;
	logic       app_c, rot_c;

	always_comb begin
		ux_c  = in_d.ctx.dx[31] ? -q_t'(quo_x) : q_t'(quo_x);
		uy_c  = in_d.ctx.dy[31] ? -q_t'(quo_y) : q_t'(quo_y);
		app_c = in_d.ctx.bone_valid && (in_d.len != '0);
		rot_c = app_c && (in_d.ctx.rdamp != '0)
			&& ((in_d.ctx.hinge == HINGE_A) || (in_d.ctx.hinge == HINGE_B));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			app_s1   <= app_c;
			ux_s1    <= ux_c;
			uy_s1    <= uy_c;
			err_s1   <= sat32($signed({32'd0, in_d.len}) - $signed({33'd0, in_d.ctx.rest}));
			tx_s1    <= (in_d.ctx.hinge == HINGE_A) ? -uy_c : uy_c;
			ty_s1    <= (in_d.ctx.hinge == HINGE_A) ? ux_c : -ux_c;
			tgt_s1   <= !rot_c ? HINGE_NONE
				: ((in_d.ctx.hinge == HINGE_A) ? HINGE_B : HINGE_A);
			rvx_s1   <= in_d.ctx.rvx;
			rvy_s1   <= in_d.ctx.rvy;
			vx_s1    <= in_d.ctx.vx;
			vy_s1    <= in_d.ctx.vy;
			stiff_s1 <= in_d.ctx.stiff;
			rdamp_s1 <= in_d.ctx.rdamp;
		end
	end

	// stage 2: first products
	logic signed [63:0] pe_s2, pvx_s2, pvy_s2, pt1_s2, pt2_s2;
	logic               app_s2;
	q_t                 ux_s2, uy_s2, tx_s2, ty_s2;
	uq_t                stiff_s2, rdamp_s2;
	logic [1:0]         tgt_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s2    <= mul32(err_s1, to_q(stiff_s1));
			pvx_s2   <= mul32(rvx_s1, ux_s1);
			pvy_s2   <= mul32(rvy_s1, uy_s1);
			pt1_s2   <= mul32(vx_s1, tx_s1);
			pt2_s2   <= mul32(vy_s1, ty_s1);
			app_s2   <= app_s1;
			ux_s2    <= ux_s1;
			uy_s2    <= uy_s1;
			tx_s2    <= tx_s1;
			ty_s2    <= ty_s1;
			stiff_s2 <= stiff_s1;
			rdamp_s2 <= rdamp_s1;
			tgt_s2   <= tgt_s1;
		end
	end

	// stage 3: scale, along-bone velocity, negated tangential velocity
	q_t         es_s3, va_s3, ntv_s3;
	logic       app_s3;
	q_t         ux_s3, uy_s3, tx_s3, ty_s3;
	uq_t        stiff_s3, rdamp_s3;
	logic [1:0] tgt_s3;
	q_t         tv_c;

	assign tv_c = sat_add(qscale(pt1_s2), qscale(pt2_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			es_s3    <= qscale(pe_s2);
			va_s3    <= sat_add(qscale(pvx_s2), qscale(pvy_s2));
			ntv_s3   <= sat_sub(32'sd0, tv_c);
			app_s3   <= app_s2;
			ux_s3    <= ux_s2;
			uy_s3    <= uy_s2;
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
			stiff_s3 <= stiff_s2;
			rdamp_s3 <= rdamp_s2;
			tgt_s3   <= tgt_s2;
		end
	end

	// stage 4
	logic signed [63:0] ps_s4, pd_s4, pm_s4;
	logic               app_s4;
	q_t                 ux_s4, uy_s4, tx_s4, ty_s4;
	logic [1:0]         tgt_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s4  <= mul32(es_s3, to_q(spring_scale));
			pd_s4  <= mul32(va_s3, to_q(stiff_s3));
			pm_s4  <= mul32(ntv_s3, to_q(rdamp_s3));
			app_s4 <= app_s3;
			ux_s4  <= ux_s3;
			uy_s4  <= uy_s3;
			tx_s4  <= tx_s3;
			ty_s4  <= ty_s3;
			tgt_s4 <= tgt_s3;
		end
	end

	// stage 5
	q_t         sp_s5, dq_s5, m_s5;
	logic       app_s5;
	q_t         ux_s5, uy_s5, tx_s5, ty_s5;
	logic [1:0] tgt_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s5  <= qscale(ps_s4);
			dq_s5  <= qscale(pd_s4);
			m_s5   <= qscale(pm_s4);
			app_s5 <= app_s4;
			ux_s5  <= ux_s4;
			uy_s5  <= uy_s4;
			tx_s5  <= tx_s4;
			ty_s5  <= ty_s4;
			tgt_s5 <= tgt_s4;
		end
	end

	// stage 6
	logic signed [63:0] pdd_s6, prx_s6, pry_s6;
	q_t                 sp_s6, ux_s6, uy_s6;
	logic               app_s6;
	logic [1:0]         tgt_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pdd_s6 <= mul32(dq_s5, to_q(damping_scale));
			prx_s6 <= mul32(tx_s5, m_s5);
			pry_s6 <= mul32(ty_s5, m_s5);
			sp_s6  <= sp_s5;
			ux_s6  <= ux_s5;
			uy_s6  <= uy_s5;
			app_s6 <= app_s5;
			tgt_s6 <= tgt_s5;
		end
	end

	// stage 7: total scalar force; drop the rotation force when no hinge acts
	q_t         s_s7, rfx_s7, rfy_s7, ux_s7, uy_s7;
	logic       app_s7;
	logic [1:0] tgt_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s7   <= sat_add(sp_s6, qscale(pdd_s6));
			rfx_s7 <= (tgt_s6 == HINGE_NONE) ? 32'sd0 : qscale(prx_s6);
			rfy_s7 <= (tgt_s6 == HINGE_NONE) ? 32'sd0 : qscale(pry_s6);
			ux_s7  <= ux_s6;
			uy_s7  <= uy_s6;
			app_s7 <= app_s6;
			tgt_s7 <= tgt_s6;
		end
	end

	// stage 8: raw force and the clamped alternative
	logic signed [63:0] pfx_s8, pfy_s8, pcx_s8, pcy_s8;
	q_t                 rfx_s8, rfy_s8;
	logic               app_s8;
	logic [1:0]         tgt_s8;
	q_t                 mm_c;

	assign mm_c = (s_s7 > 32'sd0) ? to_q(max_force) : -to_q(max_force);

	always_ff @(posedge clk) begin
		if (en) begin
			pfx_s8 <= mul32(ux_s7, s_s7);
			pfy_s8 <= mul32(uy_s7, s_s7);
			pcx_s8 <= mul32(ux_s7, mm_c);
			pcy_s8 <= mul32(uy_s7, mm_c);
			rfx_s8 <= rfx_s7;
			rfy_s8 <= rfy_s7;
			app_s8 <= app_s7;
			tgt_s8 <= tgt_s7;
		end
	end

	// stage 9
	force_ctx_t f_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s9.applied <= app_s8;
			f_s9.fx      <= qscale(pfx_s8);
			f_s9.fy      <= qscale(pfy_s8);
			f_s9.cfx     <= qscale(pcx_s8);
			f_s9.cfy     <= qscale(pcy_s8);
			f_s9.target  <= tgt_s8;
			f_s9.rfx     <= rfx_s8;
			f_s9.rfy     <= rfy_s8;
		end
	end

	// stage 10, 11: squared magnitude of the raw force
	logic signed [63:0] sqx_s10, sqy_s10;
	force_ctx_t         f_s10, f_s11;
	logic [RAD_W-1:0]   rad_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s10 <= mul32(f_s9.fx, f_s9.fx);
			sqy_s10 <= mul32(f_s9.fy, f_s9.fy);
			f_s10   <= f_s9;
			rad_s11 <= RAD_W'(sqx_s10) + RAD_W'(sqy_s10);
			f_s11   <= f_s10;
		end
	end

	assign out_v    = v_s[NST];
	assign rad      = rad_s11;
	assign side_out = f_s11;

endmodule
`default_nettype wire

// ===== rtl/bsdf_checker.sv =====
// Port-level checks for the bone spring-damper force block, bound to the top level.
`default_nettype none
module bsdf_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire bsdf_pkg::out_item_t out_item
);
	import bsdf_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a skipped bone carries no force
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.applied |->
			out_item.force_x == 0 && out_item.force_y == 0
			&& out_item.rot_target == HINGE_NONE)
		else $error("skipped bone with force");

	a_rot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rot_target == HINGE_NONE |->
			out_item.rot_force_x == 0 && out_item.rot_force_y == 0)
		else $error("rotation force without target");

	// input may only stall while a result is held on the output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind bone_spring_damper_force bsdf_checker u_bsdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire

// ===== verif/bsdf_checker.sv =====
// Checker for the bone spring-damper force block: predicts each result and compares it.
module bsdf_scoreboard (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire bsdf_pkg::in_item_t  in_item,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire bsdf_pkg::out_item_t out_item,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_idx,
	input  wire logic [30:0]         cfg_wdata,
	output int                       fail_count,
	output int                       pending
);
	import bsdf_pkg::*;

	longint lim_force, k_spring, k_damp;
	out_item_t force_q[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor of the Q16.16 product, saturated
	function automatic longint fmul(longint a, longint b);
		longint p;
		p = clamp32(a) * clamp32(b);
		return clamp32(p >>> 16);
	endfunction

	function automatic longint root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint length_of(longint x, longint y);
		return root(longint'(x * x) + longint'(y * y));
	endfunction

	function automatic out_item_t bone_force(in_item_t b);
		out_item_t r;
		longint dx, dy, blen, ux, uy, err, sp, va, dp, s, fx, fy, m;
		longint tx, ty, vx, vy, tv;
		r = '0;
		dx = longint'(b.delta_x);
		dy = longint'(b.delta_y);
		blen = length_of(dx, dy);
		if (b.bone_valid && blen != 0) begin
			ux = (dx * 65536) / blen;
			uy = (dy * 65536) / blen;
			err = clamp32(blen - longint'(b.rest_length));
			sp = fmul(fmul(err, b.stiffness), k_spring);
			va = clamp32(fmul(clamp32(longint'(b.vel_b_x) - b.vel_a_x), ux)
				+ fmul(clamp32(longint'(b.vel_b_y) - b.vel_a_y), uy));
			dp = fmul(fmul(va, b.stiffness), k_damp);
			s = clamp32(sp + dp);
			fx = fmul(ux, s);
			fy = fmul(uy, s);
			if (length_of(fx, fy) > lim_force) begin
				m = (s > 0) ? lim_force : -lim_force;
				fx = fmul(ux, m);
				fy = fmul(uy, m);
			end
			r.applied = 1'b1;
			r.force_x = fx[31:0];
			r.force_y = fy[31:0];
			if ((b.pivot_end == HINGE_A || b.pivot_end == HINGE_B) && b.rot_damping != 0) begin
				if (b.pivot_end == HINGE_A) begin
					tx = -uy; ty = ux; vx = b.vel_b_x; vy = b.vel_b_y;
					r.rot_target = HINGE_B;
				end else begin
					tx = uy; ty = -ux; vx = b.vel_a_x; vy = b.vel_a_y;
					r.rot_target = HINGE_A;
				end
				tv = clamp32(fmul(vx, tx) + fmul(vy, ty));
				m = fmul(clamp32(-tv), b.rot_damping);
				r.rot_force_x = 32'(fmul(tx, m));
				r.rot_force_y = 32'(fmul(ty, m));
			end
		end
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			lim_force = longint'(MAX_FORCE_RST);
			k_spring = longint'(SPRING_SCALE_RST);
			k_damp = longint'(DAMPING_SCALE_RST);
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_FORCE: lim_force = longint'(cfg_wdata);
					CFG_SPRING_SCALE: k_spring = longint'(cfg_wdata);
					CFG_DAMPING_SCALE: k_damp = longint'(cfg_wdata);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (force_q.size() == 0) begin
					report("unexpected item", 0, 0);
				end else begin
					e = force_q.pop_front();
					if (out_item.applied !== e.applied)
						report("applied", out_item.applied, e.applied);
					if (out_item.force_x !== e.force_x)
						report("force_x", out_item.force_x, e.force_x);
					if (out_item.force_y !== e.force_y)
						report("force_y", out_item.force_y, e.force_y);
					if (out_item.rot_target !== e.rot_target)
						report("rot_target", out_item.rot_target, e.rot_target);
					if (out_item.rot_force_x !== e.rot_force_x)
						report("rot_force_x", out_item.rot_force_x, e.rot_force_x);
					if (out_item.rot_force_y !== e.rot_force_y)
						report("rot_force_y", out_item.rot_force_y, e.rot_force_y);
				end
			end
			if (in_valid && in_ready)
				force_q.insert(force_q.size(), bone_force(in_item));
		end
		pending = force_q.size();
	end
endmodule

// ===== verif/tb.sv =====
// Stimulus and verdict for the bone spring-damper force block.
module tb;
	import bsdf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	in_item_t in_item = '0;
	out_item_t out_item;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = CFG_MAX_FORCE;
	logic [30:0] cfg_wdata = '0;
	int fail_count, pending;
	int out_mode = 0;

	always #4 clk = ~clk;

	bone_spring_damper_force uut (.*);
	bsdf_scoreboard chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (out_mode == 0) return 0;
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		int g;
		g = gap_len();
		if (g != 0) begin
			out_ready <= 1'b0;
			repeat (g) @(posedge clk);
		end
		out_ready <= 1'b1;
		@(posedge clk);
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			3: return $urandom_range(0, 32'h3ffffff) - 32'h2000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_uq();
		case ($urandom_range(0, 4))
			0: return 31'h7fffffff;
			1: return 31'd0;
			2: return 31'($urandom_range(0, 32'h3ffff));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_bone();
		in_item_t b;
		b.bone_valid = ($urandom_range(0, 9) != 0);
		b.delta_x = rand_word();
		b.delta_y = rand_word();
		if ($urandom_range(0, 19) == 0) begin
			b.delta_x = 0;
			b.delta_y = 0;
		end
		b.vel_a_x = rand_word();
		b.vel_a_y = rand_word();
		b.vel_b_x = rand_word();
		b.vel_b_y = rand_word();
		b.rest_length = rand_uq();
		b.stiffness = rand_uq();
		b.pivot_end = 2'($urandom_range(0, 3));
		b.rot_damping = rand_uq();
		return b;
	endfunction

	task automatic send(in_item_t b);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [30:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic bone(logic v, int dx, int dy, int vax, int vay, int vbx, int vby,
			int rest, int st, logic [1:0] h, int rd);
		in_item_t b;
		b.bone_valid = v;
		b.delta_x = dx; b.delta_y = dy;
		b.vel_a_x = vax; b.vel_a_y = vay; b.vel_b_x = vbx; b.vel_b_y = vby;
		b.rest_length = 31'(rest); b.stiffness = 31'(st); b.pivot_end = h;
		b.rot_damping = 31'(rd);
		send(b);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed bones
		bone(1, 65536, 0, 0, 0, 0, 0, 32768, 65536, HINGE_NONE, 0);
		bone(1, 0, 131072, 0, 0, 65536, 0, 65536, 65536, HINGE_A, 65536);
		bone(1, 65536, 65536, 65536, 0, 0, 65536, 0, 131072, HINGE_B, 65536);
		bone(0, 65536, 0, 0, 0, 0, 0, 0, 65536, HINGE_A, 65536);
		bone(1, 0, 0, 5, 5, 5, 5, 0, 65536, HINGE_A, 65536);
		bone(1, 65536, 0, 0, 65536, 0, 0, 0, 65536, 2'd3, 65536);
		bone(1, 65536, 0, 0, 65536, 0, 0, 0, 65536, HINGE_A, 0);
		bone(1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, HINGE_A, 32'h7fffffff);
		bone(1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, HINGE_B, 32'h7fffffff);
		bone(1, 1, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, HINGE_A, 1);
		bone(1, 32'hffff0000, 0, 0, 0, 0, 0, 0, 65536, HINGE_B, 65536);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					set_reg(CFG_MAX_FORCE, 31'h7fffffff);
					set_reg(CFG_SPRING_SCALE, 31'h7fffffff);
					set_reg(CFG_DAMPING_SCALE, 31'h7fffffff);
				end
				2: begin
					set_reg(CFG_MAX_FORCE, 31'd0);
					set_reg(CFG_SPRING_SCALE, 31'd0);
					set_reg(CFG_DAMPING_SCALE, 31'd0);
				end
				3, 4, 5: begin
					set_reg(CFG_MAX_FORCE, rand_uq());
					set_reg(CFG_SPRING_SCALE, rand_uq());
					set_reg(CFG_DAMPING_SCALE, rand_uq());
					set_reg(2'd3, 31'($urandom));
				end
				default: ;
			endcase
			out_mode = (ph % 3 != 0);
			for (int i = 0; i < 90; i++) send(rand_bone());
			drain();
		end
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/bsdf_pkg.sv
rtl/bsdf_isqrt.sv
rtl/bsdf_div.sv
rtl/bsdf_calc.sv
rtl/bone_spring_damper_force.sv
rtl/bsdf_checker.sv
verif/bsdf_checker.sv
verif/tb.sv
